[rtl/cwlp_pkg.sv]
// Shared types and constants for the chunked waveform loader and player.
package cwlp_pkg;

  localparam int STORE_DEPTH_DEF = 1024;
  localparam int SLOT_W = 16;
  localparam int WORD_W = 32;
  localparam int LEN_W = 8;
  localparam int CAP_W = 11;
  localparam int APB_AW = 3;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_TICK   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_PLAY   = 2'd2
  } kind_t;

  typedef enum logic {
    REG_CAPACITY = 1'b0
  } reg_idx_t;

  // One access request to the waveform memory.
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } ram_req_t;

endpackage

[rtl/cwlp_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface cwlp_item_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic [cwlp_pkg::SLOT_W-1:0]  start_slot;
  logic [cwlp_pkg::SLOT_W-1:0]  period_len;
  logic [cwlp_pkg::LEN_W-1:0]   chunk_len;
  logic [cwlp_pkg::WORD_W-1:0]  sample_word;

  modport source (output valid, opcode, start_slot, period_len, chunk_len, sample_word,
                  input ready);
  modport sink (input valid, opcode, start_slot, period_len, chunk_len, sample_word,
                output ready);
endinterface

interface cwlp_result_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   result_kind;
  logic [cwlp_pkg::WORD_W-1:0]  drive_value;
  logic                         playing;

  modport source (output valid, result_kind, drive_value, playing, input ready);
  modport sink (input valid, result_kind, drive_value, playing, output ready);
endinterface

[rtl/cwlp_wave_ram.sv]
// Single-clock waveform memory: one write port, one read port, registered read data.
module cwlp_wave_ram #(
  parameter int DEPTH = cwlp_pkg::STORE_DEPTH_DEF
) (
  input  logic                        clk,
  input  cwlp_pkg::ram_req_t          req,
  output logic [cwlp_pkg::WORD_W-1:0] rd_data
);
  localparam int AW = $clog2(DEPTH);

  logic [cwlp_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  // Read data holds until the next read, so a stalled result keeps its word.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr[AW-1:0]];
    end
  end
endmodule

[rtl/chunked_waveform_load_and_playback.sv]
// Top level: chunked waveform loader with cyclic playback from a single memory.
//
// Items arrive on the item channel: a chunk header (start slot, period, length),
// sample words that fill consecutive slots, or playback ticks. Results leave on
// the result channel: accept or reject for a chunk, and one played word per tick.
// A header with words gives no result; the last sample word of the chunk does.
// The buffer_capacity register sits at APB byte address 0.
//
// One item per cycle is sustained while the result receiver keeps up. After its
// beat is accepted, a result passes the stage register, which loads with the
// memory read on the accept edge, and then the output register, which loads when
// the stage can move. Ticks read the memory and samples write it on the accept
// edge, so back-to-back writes and reads never collide.
// Reset clears playback and chunk state and sets the capacity to 1024; memory
// contents are left as they are. When the receiver stalls, the finished result
// waits in the output register and one more result waits behind it; no item is
// taken while both are full.
module chunked_waveform_load_and_playback #(
  parameter int STORE_DEPTH = cwlp_pkg::STORE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  cwlp_item_if.sink                           item,
  cwlp_result_if.source                       result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cwlp_pkg::APB_AW-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  localparam logic [cwlp_pkg::SLOT_W:0] DEPTH_X = (cwlp_pkg::SLOT_W+1)'(STORE_DEPTH);

  // Configuration.
  logic [cwlp_pkg::CAP_W-1:0] buffer_capacity;
  logic                       cfg_write;
  cwlp_pkg::reg_idx_t         cfg_idx;

  // Control state.
  logic                        play_enable, play_enable_next;
  logic [cwlp_pkg::SLOT_W-1:0] play_index, play_index_next;
  logic [cwlp_pkg::SLOT_W-1:0] period_slots, period_slots_next;
  logic [cwlp_pkg::SLOT_W-1:0] write_slot, write_slot_next;
  logic [cwlp_pkg::LEN_W-1:0]  words_left, words_left_next;
  logic [cwlp_pkg::SLOT_W-1:0] pending_period, pending_period_next;

  // Stage between the memory read and the output register.
  logic           s1_valid;
  cwlp_pkg::kind_t s1_kind;
  logic           s1_playing;
  logic           s1_use_mem;
  logic           s1_move;

  // Output register.
  logic                        out_valid;
  cwlp_pkg::kind_t             out_kind;
  logic [cwlp_pkg::WORD_W-1:0] out_drive;
  logic                        out_playing;

  logic                        item_fire;
  logic                        emit;
  cwlp_pkg::kind_t             emit_kind;
  logic                        emit_mem;
  cwlp_pkg::ram_req_t          ram_req;
  logic [cwlp_pkg::WORD_W-1:0] rd_data;

  logic [cwlp_pkg::SLOT_W:0]   cap_eff;
  logic [cwlp_pkg::SLOT_W:0]   chunk_end;
  logic [cwlp_pkg::SLOT_W-1:0] slot_inc;
  logic [cwlp_pkg::SLOT_W-1:0] index_inc;
  logic [cwlp_pkg::LEN_W-1:0]  words_dec;

  // APB port.
  assign pready    = 1'b1;
  assign cfg_idx   = cwlp_pkg::reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_capacity <= cwlp_pkg::CAP_RESET;
    end else if (cfg_write && cfg_idx == cwlp_pkg::REG_CAPACITY) begin
      buffer_capacity <= pwdata[cwlp_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx == cwlp_pkg::REG_CAPACITY) begin
      prdata = {{(32-cwlp_pkg::CAP_W){1'b0}}, buffer_capacity};
    end
  end

  // Handshake: the stage register frees up when it can move into the output.
  assign s1_move    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s1_move;
  assign item_fire  = item.valid && item.ready;

  assign cap_eff = ({{(cwlp_pkg::SLOT_W+1-cwlp_pkg::CAP_W){1'b0}}, buffer_capacity} > DEPTH_X)
                   ? DEPTH_X
                   : {{(cwlp_pkg::SLOT_W+1-cwlp_pkg::CAP_W){1'b0}}, buffer_capacity};
  assign chunk_end = {1'b0, item.start_slot}
                   + {{(cwlp_pkg::SLOT_W+1-cwlp_pkg::LEN_W){1'b0}}, item.chunk_len};
  assign slot_inc  = write_slot + 1'b1;
  assign index_inc = play_index + 1'b1;
  assign words_dec = words_left - 1'b1;

  always_comb begin
    play_enable_next    = play_enable;
    play_index_next     = play_index;
    period_slots_next   = period_slots;
    write_slot_next     = write_slot;
    words_left_next     = words_left;
    pending_period_next = pending_period;
    emit                = 1'b0;
    emit_kind           = cwlp_pkg::KIND_ACCEPT;
    emit_mem            = 1'b0;
    ram_req             = '0;
    ram_req.waddr       = write_slot;
    ram_req.wdata       = item.sample_word;
    ram_req.raddr       = play_index;

    if (item_fire) begin
      case (item.opcode)
        cwlp_pkg::OP_HEADER: begin
          play_enable_next = 1'b0;
          words_left_next  = '0;
          emit             = 1'b1;
          if (chunk_end > cap_eff) begin
            emit_kind = cwlp_pkg::KIND_REJECT;
          end else begin
            write_slot_next     = item.start_slot;
            pending_period_next = item.period_len;
            words_left_next     = item.chunk_len;
            if (item.chunk_len == '0) begin
              // An empty chunk commits straight away.
              period_slots_next = item.period_len;
              if (item.start_slot >= item.period_len) begin
                play_index_next  = '0;
                play_enable_next = 1'b1;
              end
            end else begin
              emit = 1'b0;
            end
          end
        end
        cwlp_pkg::OP_SAMPLE: begin
          if (words_left != '0) begin
            ram_req.we      = ({1'b0, write_slot} < DEPTH_X);
            write_slot_next = slot_inc;
            words_left_next = words_dec;
            if (words_dec == '0) begin
              period_slots_next = pending_period;
              emit              = 1'b1;
              if (slot_inc >= pending_period) begin
                play_index_next  = '0;
                play_enable_next = 1'b1;
              end
            end
          end
        end
        cwlp_pkg::OP_TICK: begin
          emit      = 1'b1;
          emit_kind = cwlp_pkg::KIND_PLAY;
          if (play_enable) begin
            emit_mem   = ({1'b0, play_index} < DEPTH_X);
            ram_req.re = emit_mem;
            play_index_next = (index_inc >= period_slots) ? '0 : index_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_enable    <= 1'b0;
      play_index     <= '0;
      period_slots   <= '0;
      write_slot     <= '0;
      words_left     <= '0;
      pending_period <= '0;
    end else begin
      play_enable    <= play_enable_next;
      play_index     <= play_index_next;
      period_slots   <= period_slots_next;
      write_slot     <= write_slot_next;
      words_left     <= words_left_next;
      pending_period <= pending_period_next;
    end
  end

  cwlp_wave_ram #(
    .DEPTH (STORE_DEPTH)
  ) u_wave_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // Result stage: waits here while the memory read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_fire) begin
      s1_valid <= emit;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1_kind    <= emit_kind;
      s1_playing <= play_enable_next;
      s1_use_mem <= emit_mem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_kind    <= s1_kind;
      out_drive   <= s1_use_mem ? rd_data : '0;
      out_playing <= s1_playing;
    end
  end

  assign result.valid       = out_valid;
  assign result.result_kind = out_kind;
  assign result.drive_value = out_drive;
  assign result.playing     = out_playing;

  // A chunk still being filled means playback is stopped.
  a_open_chunk_stops_play: assert property (@(posedge clk) disable iff (rst)
    words_left != '0 |-> !play_enable)
    else $error("playback enabled while a chunk is open");

  // While playing, the index stays inside the period or sits at slot 0.
  a_index_in_period: assert property (@(posedge clk) disable iff (rst)
    play_enable |-> (play_index == '0 || play_index < period_slots))
    else $error("play index outside the period");

  // Only ticks carry a nonzero word.
  a_drive_only_on_play: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != cwlp_pkg::KIND_PLAY |-> out_drive == '0)
    else $error("nonzero word on a chunk result");

  // A rejected chunk always leaves playback stopped.
  a_reject_not_playing: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == cwlp_pkg::KIND_REJECT |-> !out_playing)
    else $error("rejected chunk reports playing");
endmodule
